### sv/lts_pkg.sv
package lts_pkg;

	// operation codes on the func port
	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_READ    = 2'd1;
	localparam logic [1:0] FUNC_RECORD  = 2'd2;
	localparam logic [1:0] FUNC_ELAPSED = 2'd3;

	localparam int FUNC_W   = 2;
	localparam int SLOT_W   = 4;
	localparam int COUNT_W  = 64;
	localparam int TPM_W    = 10;
	localparam int TPM_RESET = 80;

	// number of lap slots, 1 to 16 (2^SLOT_W slot numbers)
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_IW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// one quotient bit per step
	localparam int DIV_STEPS = COUNT_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic               go;
		logic [COUNT_W-1:0] dividend;
		logic [TPM_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [COUNT_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic               wr_en;
		logic [SLOT_W-1:0]  wr_slot;
		logic [COUNT_W-1:0] wr_data;
		logic [SLOT_W-1:0]  rd_slot;
	} lap_req_t;

endpackage

### sv/lts_divider.sv
module lts_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  lts_pkg::div_req_t  req,
	output lts_pkg::div_rsp_t  rsp
);
	import lts_pkg::*;

	logic [COUNT_W-1:0] quo_q;
	logic [TPM_W-1:0]   rem_q;
	logic [TPM_W-1:0]   dvsr_q;
	logic [DIV_CW-1:0]  cnt_q;
	logic               run_q;
	logic               done_q;

	logic [TPM_W:0]     trial;
	logic [TPM_W:0]     dvsr_ext;
	logic               ge;
	logic [TPM_W-1:0]   rem_nx;

	// restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, quo_q[COUNT_W-1]};
		dvsr_ext = {1'b0, dvsr_q};
		ge       = (trial >= dvsr_ext);
		rem_nx   = ge ? TPM_W'(trial - dvsr_ext) : trial[TPM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dvsr_q <= req.divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[COUNT_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### sv/lts_lap_store.sv
module lts_lap_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lts_pkg::lap_req_t            req,
	output logic [lts_pkg::COUNT_W-1:0]  rd_data
);
	import lts_pkg::*;

	logic [COUNT_W-1:0]   marks_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;

	logic [SLOT_IW-1:0] wr_idx;
	logic [SLOT_IW-1:0] rd_idx;
	logic               wr_in_range;
	logic               rd_in_range;

	always_comb begin
		wr_idx      = SLOT_IW'(req.wr_slot);
		rd_idx      = SLOT_IW'(req.rd_slot);
		wr_in_range = (32'(req.wr_slot) < 32'(NUM_SLOTS));
		rd_in_range = (32'(req.rd_slot) < 32'(NUM_SLOTS));
	end

	// cleared slots read as zero until first recorded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en && wr_in_range) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en && wr_in_range) begin
			marks_q[wr_idx] <= req.wr_data;
		end
	end

	assign rd_data = (rd_in_range && valid_q[rd_idx]) ? marks_q[rd_idx] : '0;

endmodule

### sv/lap_timestamp_unit.sv
// channel   | ports                         | direction | handshake
// ----------+-------------------------------+-----------+----------------------------
// request   | func, slot                    | in        | start && !busy
// result    | micros                        | out       | done, one cycle, no stall
// config    | cfg_wdata (ticks per micro)   | in        | cfg_we, no wait
//
// a tick request advances the tick count and busy stays low
// read, record and elapsed requests run the shared radix-2 divider,
// one quotient bit per cycle; done rises in the cycle that busy falls,
// and only read and elapsed requests give a result; a record gives none
// asynchronous active-low reset clears the tick count, the lap slots and
// sets ticks per micro to 80; the result strobe cannot be held off
module lap_timestamp_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [lts_pkg::FUNC_W-1:0]    func,
	input  logic [lts_pkg::SLOT_W-1:0]    slot,
	output logic                          done,
	output logic [lts_pkg::COUNT_W-1:0]   micros,
	input  logic                          cfg_we,
	input  logic [lts_pkg::TPM_W-1:0]     cfg_wdata
);
	import lts_pkg::*;

	state_t state_q, state_nx;

	logic [COUNT_W-1:0] tick_count_q;
	logic [TPM_W-1:0]   tpm_q;
	logic [FUNC_W-1:0]  func_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               done_q;
	logic [COUNT_W-1:0] micros_q;

	logic               accept;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	lap_req_t           lap_req;
	logic [COUNT_W-1:0] mark;

	logic               res_en;
	logic [COUNT_W-1:0] res_val;

	assign accept = start && (state_q == ST_IDLE);

	// sequencer: idle, or waiting on the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx         = state_q;
		div_req.go       = 1'b0;
		div_req.dividend = tick_count_q;
		div_req.divisor  = tpm_q;
		lap_req.wr_en    = 1'b0;
		lap_req.wr_slot  = slot_q;
		lap_req.wr_data  = div_rsp.quotient;
		lap_req.rd_slot  = slot_q;
		res_en           = 1'b0;
		res_val          = div_rsp.quotient;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (func != FUNC_TICK)) begin
					div_req.go = 1'b1;
					state_nx   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_nx = ST_IDLE;
					unique case (func_q)
						FUNC_RECORD: begin
							lap_req.wr_en = 1'b1;
						end
						FUNC_ELAPSED: begin
							// wraps when the mark is later than now
							res_en  = 1'b1;
							res_val = div_rsp.quotient - mark;
						end
						default: begin
							res_en = (func_q == FUNC_READ);
						end
					endcase
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// tick count, advanced by each accepted tick request, wraps at 2^64
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
		end else if (accept && (func == FUNC_TICK)) begin
			tick_count_q <= tick_count_q + 1'b1;
		end
	end

	// conversion divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q <= TPM_W'(TPM_RESET);
		end else if (cfg_we) begin
			tpm_q <= cfg_wdata;
		end
	end

	// request fields held for the length of the division
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			slot_q <= slot;
		end
	end

	// result register, one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_en;
		end
	end

	always_ff @(posedge clk) begin
		if (res_en) begin
			micros_q <= res_val;
		end
	end

	lts_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lts_lap_store u_laps (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (lap_req),
		.rd_data (mark)
	);

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign micros = micros_q;

endmodule

### sv/lts_checker.sv
module lts_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [lts_pkg::FUNC_W-1:0]    func,
	input  logic                          done
);
	import lts_pkg::*;

	// a tick request never makes the block busy
	a_tick_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FUNC_TICK)) |=> !busy)
		else $error("tick request raised busy");

	// any other request starts a division
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func != FUNC_TICK)) |=> busy)
		else $error("query request did not raise busy");

	// a result only shows once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// one request gives at most one strobe
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// a result strobe follows the end of a division
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(busy, 2))
		else $error("result strobe without a division");

endmodule

bind lap_timestamp_unit lts_checker u_lts_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.func   (func),
	.done   (done)
);
